### src/ssnd_pkg.sv
// shared types, request codes and glyph table for the seven-segment number driver
package ssnd_pkg;

  localparam int MAX_DIGITS         = 8;
  localparam int NUM_DIGITS_DEFAULT = 8;
  localparam int IDX_W              = 3;
  localparam int VALUE_W            = 32;
  localparam int BCD_W              = 4 * MAX_DIGITS;
  localparam int DABBLE_STAGES      = 4;
  localparam int STEPS_PER_STAGE    = VALUE_W / DABBLE_STAGES;

  localparam logic [2:0] REQ_HEX    = 3'd0;
  localparam logic [2:0] REQ_DEC    = 3'd1;
  localparam logic [2:0] REQ_BLANK  = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_ALL_ON = 3'd4;
  localparam logic [2:0] REQ_SINGLE = 3'd5;

  localparam logic [7:0] SEG_OFF = 8'h00;
  localparam logic [7:0] SEG_ON  = 8'hFF;

  localparam logic [VALUE_W-1:0] POW10 [MAX_DIGITS] = '{
    32'd1, 32'd10, 32'd100, 32'd1000,
    32'd10000, 32'd100000, 32'd1000000, 32'd10000000
  };

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   digit_select;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] digit_index;
    logic [7:0]       segments;
    logic             last;
  } res_t;

  // value rotates through the converter and comes back whole after all steps
  typedef struct packed {
    logic [2:0]         req_type;
    logic [IDX_W-1:0]   digit_select;
    logic [VALUE_W-1:0] value;
    logic [BCD_W-1:0]   bcd;
  } conv_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] last_idx;
  } frame_ctl_t;

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] seg;
    unique case (nib)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h67;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

### src/seven_segment_number_driver_core.sv
// top level of the seven-segment number driver
//
// req channel: one display command per transfer (type, 32-bit value, digit
// select). res channel: digit writes (index, segment byte, last flag), least
// significant digit first, last set on the final write of a command.
// hex, decimal, decimal-blanked, clear and all-on give NUM_DIGITS writes;
// single gives one write, or none when the digit is out of range; unused
// types give none.
// the first write of a command reaches res through four bcd converter stages,
// the pattern stage, the frame buffer and the output register. throughput:
// the res side sends one write per cycle while res_stall is low; commands
// with no writes flow in at one per cycle while the pipeline is not stalled.
// up to five commands are held in flight behind the frame being sent.
// reset: rst empties every stage; no results are pending.
// stall: res_stall holds the output register and backs up stage by stage;
// req_stall rises only once every stage before the output register is full.
module seven_segment_number_driver_core
  import ssnd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  conv_t      link       [DABBLE_STAGES+1];
  logic       link_valid [DABBLE_STAGES+1];
  logic       link_stall [DABBLE_STAGES+1];
  logic       pat_valid;
  logic       pat_stall;
  logic [7:0] pat_segs [NUM_DIGITS];
  frame_ctl_t pat_ctl;

  assign link[0]       = '{req_type: req.req_type, digit_select: req.digit_select,
                           value: req.value, bcd: '0};
  assign link_valid[0] = req_valid;
  assign req_stall     = link_stall[0];

  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    ssnd_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_stall  (link_stall[g]),
      .in_data   (link[g]),
      .out_valid (link_valid[g+1]),
      .out_stall (link_stall[g+1]),
      .out_data  (link[g+1])
    );
  end

  ssnd_pattern #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_pattern (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[DABBLE_STAGES]),
    .in_stall  (link_stall[DABBLE_STAGES]),
    .in_data   (link[DABBLE_STAGES]),
    .out_valid (pat_valid),
    .out_stall (pat_stall),
    .segs      (pat_segs),
    .ctl       (pat_ctl)
  );

  ssnd_serializer #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pat_valid),
    .in_stall  (pat_stall),
    .in_segs   (pat_segs),
    .in_ctl    (pat_ctl),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res)
  );

endmodule

### src/ssnd_dabble.sv
// one registered stage of the shift-and-add-3 binary to bcd converter
module ssnd_dabble
  import ssnd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  conv_t in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output conv_t out_data
);

  logic [VALUE_W-1:0] v;
  logic [BCD_W-1:0]   b;
  conv_t              data_next;

  always_comb begin
    v = in_data.value;
    b = in_data.bcd;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], v[VALUE_W-1]};
      v = {v[VALUE_W-2:0], v[VALUE_W-1]};
    end
    data_next              = in_data;
    data_next.value        = v;
    data_next.bcd          = b;
  end

  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      out_data <= data_next;
    end
  end

endmodule

### src/ssnd_pattern.sv
// segment pattern stage: glyphs per digit and the range of digits to write
module ssnd_pattern
  import ssnd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  conv_t      in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] segs [NUM_DIGITS],
  output frame_ctl_t ctl
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

  logic [7:0] segs_next [NUM_DIGITS];
  frame_ctl_t ctl_next;
  logic       writes;
  logic [3:0] dgt;

  always_comb begin
    dgt = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dgt = in_data.bcd[4*i +: 4];
      case (in_data.req_type)
        REQ_HEX:    segs_next[i] = glyph(in_data.value[4*i +: 4]);
        REQ_DEC:    segs_next[i] = glyph(dgt);
        REQ_BLANK:  segs_next[i] = (i == 0 || in_data.value >= POW10[i]) ? glyph(dgt)
                                                                          : SEG_OFF;
        REQ_CLEAR:  segs_next[i] = SEG_OFF;
        REQ_ALL_ON: segs_next[i] = SEG_ON;
        REQ_SINGLE: segs_next[i] = glyph(in_data.value[3:0]);
        default:    segs_next[i] = SEG_OFF;
      endcase
    end
  end

  always_comb begin
    ctl_next = '{first_idx: '0, last_idx: LAST_IDX};
    writes   = 1'b0;
    case (in_data.req_type) inside
      REQ_HEX, REQ_DEC, REQ_BLANK, REQ_CLEAR, REQ_ALL_ON: begin
        writes = 1'b1;
      end
      REQ_SINGLE: begin
        ctl_next = '{first_idx: in_data.digit_select, last_idx: in_data.digit_select};
        writes   = ({1'b0, in_data.digit_select} < (IDX_W + 1)'(NUM_DIGITS));
      end
      default: begin
        writes = 1'b0;
      end
    endcase
  end

  assign in_stall = out_valid && out_stall;

  // commands with no writes are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid && writes;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      segs <= segs_next;
      ctl  <= ctl_next;
    end
  end

endmodule

### src/ssnd_serializer.sv
// frame buffer and output register, one digit write per transfer
module ssnd_serializer
  import ssnd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_segs [NUM_DIGITS],
  input  frame_ctl_t in_ctl,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data
);

  logic             frame_valid;
  logic [7:0]       frame_segs [NUM_DIGITS];
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic             emit;
  logic             emit_last;
  logic             frame_load;
  logic [7:0]       seg_sel;

  always_comb begin
    seg_sel = SEG_OFF;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (IDX_W'(k) == idx) begin
        seg_sel = frame_segs[k];
      end
    end
  end

  assign emit       = frame_valid && (!out_valid || !out_stall);
  assign emit_last  = (idx == last_idx);
  assign in_stall   = frame_valid && !(emit && emit_last);
  assign frame_load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_load) begin
      frame_valid <= 1'b1;
    end else if (emit && emit_last) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_load) begin
      frame_segs <= in_segs;
      idx        <= in_ctl.first_idx;
      last_idx   <= in_ctl.last_idx;
    end else if (emit) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= '{digit_index: idx, segments: seg_sel, last: emit_last};
    end
  end

  a_frame_in_range: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> idx <= last_idx)
    else $error("digit counter ran past the last digit of the frame");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> frame_valid)
    else $error("frame released before its last write");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    emit && frame_valid && !emit_last |=> frame_valid && idx == $past(idx) + IDX_W'(1))
    else $error("digit counter did not step after a write");

endmodule
